// File: src/cnn_pkg.sv
// ----------------------------------------------------------------------------
// cnn_pkg
// Shared widths, codes and controller/datapath interface types for the
// condensed nearest neighbor prototype selector.
// ----------------------------------------------------------------------------
package cnn_pkg;

	localparam int FEAT_W    = 16;
	localparam int LABEL_W   = 4;
	localparam int SLOTS     = 4;
	localparam int SLOT_W    = 2;
	localparam int SUM_W     = 22;
	localparam int DIST_W    = 34;
	localparam int PROD_W    = 2 * FEAT_W;
	localparam int VEC_W     = SLOTS * FEAT_W;
	localparam int WORD_W    = VEC_W + LABEL_W;

	typedef logic [SLOTS-1:0][SUM_W-1:0] sum_vec_t;
	typedef logic [VEC_W-1:0]            feat_vec_t;

	// Source of the feature memory read address.
	typedef enum logic [1:0] {
		FSEL_ADDR,
		FSEL_SORT,
		FSEL_KORD
	} fsel_t;

	typedef struct packed {
		logic  load;
		logic  div_start;
		logic  cen_cap;
		logic  feat_rd;
		fsel_t fsel;
		logic  dist_start;
		logic  dist_wr;
		logic  dist_rd;
		logic  di_cap;
		logic  rank_clr;
		logic  rank_step;
		logic  j_before_i;
		logic  sort_wr;
		logic  sort_rd;
		logic  s_cap;
		logic  q_cap;
		logic  best_upd;
		logic  best_first;
		logic  korder_rd;
		logic  korder_wr;
		logic  seed;
		logic  emit;
		logic  last;
		logic  clear;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic dist_done;
		logic s_kept;
		logic label_diff;
	} sts_t;

endpackage

// File: src/condensed_nearest_neighbor.sv
// ----------------------------------------------------------------------------
// condensed_nearest_neighbor
// Hart's condensed nearest neighbor prototype selector over Q8.8 samples.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Word
// input     in         start high, busy low   class_label, feature_0..3, end_of_set
// result    out        strobe, one cycle      kept_label, kept_feature_0..3, last_kept
//
// A sample word is taken in every cycle with start high while busy is low,
// one per cycle. The word carrying end_of_set starts the run, and busy stays
// high until the last result is shown. The run divides the feature sums for
// the centroid, finds each sample's centroid distance, ranks the samples by
// that distance, and in each pass compares every unkept sample with each
// stored prototype, bounded by the single-port sample memory and the
// one-feature-per-cycle distance unit. Readout reads the kept order, then
// the sample, then emits each result. The receiver cannot stall; strobe is
// high for exactly one cycle per result. Reset is asynchronous and
// the memories need no clearing pass: only written entries are ever read.
//
// Samples arriving while the store already holds MAX_SAMPLES are dropped,
// but an end_of_set on such a sample still starts the run.
// ----------------------------------------------------------------------------
module condensed_nearest_neighbor import cnn_pkg::*; #(
	parameter int MAX_SAMPLES   = 64,
	parameter int FEATURE_COUNT = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [LABEL_W-1:0] class_label,
	input  logic [FEAT_W-1:0]  feature_0,
	input  logic [FEAT_W-1:0]  feature_1,
	input  logic [FEAT_W-1:0]  feature_2,
	input  logic [FEAT_W-1:0]  feature_3,
	input  logic               end_of_set,
	output logic               strobe,
	output logic [LABEL_W-1:0] kept_label,
	output logic [FEAT_W-1:0]  kept_feature_0,
	output logic [FEAT_W-1:0]  kept_feature_1,
	output logic [FEAT_W-1:0]  kept_feature_2,
	output logic [FEAT_W-1:0]  kept_feature_3,
	output logic               last_kept
);

	// Index width addresses one stored sample; count width also holds the
	// full count itself.
	localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] addr;
	logic [IW-1:0] waddr;
	logic [CW-1:0] n;

	// The controller sequences every phase and holds the loop counters; the
	// datapath owns the memories and the feature arithmetic.
	cnn_ctrl #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.IW          (IW),
		.CW          (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.end_of_set (end_of_set),
		.busy       (busy),
		.cmd        (cmd),
		.addr       (addr),
		.waddr      (waddr),
		.n          (n),
		.sts        (sts)
	);

	cnn_datapath #(
		.MAX_SAMPLES   (MAX_SAMPLES),
		.FEATURE_COUNT (FEATURE_COUNT),
		.IW            (IW),
		.CW            (CW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.addr           (addr),
		.waddr          (waddr),
		.n              (n),
		.sts            (sts),
		.class_label    (class_label),
		.feature_0      (feature_0),
		.feature_1      (feature_1),
		.feature_2      (feature_2),
		.feature_3      (feature_3),
		.strobe         (strobe),
		.kept_label     (kept_label),
		.kept_feature_0 (kept_feature_0),
		.kept_feature_1 (kept_feature_1),
		.kept_feature_2 (kept_feature_2),
		.kept_feature_3 (kept_feature_3),
		.last_kept      (last_kept)
	);

	// A result word always comes out of a run, never from the idle state.
	a_strobe_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result word outside a run");

endmodule

// File: src/cnn_div.sv
// ----------------------------------------------------------------------------
// cnn_div
// Four-lane restoring divider: one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module cnn_div import cnn_pkg::*; #(
	parameter int CW = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [CW-1:0]  divisor,
	input  sum_vec_t       dividend,
	output sum_vec_t       quotient,
	output logic           done
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SLOTS-1:0][CW-1:0] rem_q;
	sum_vec_t                 quo_q;
	logic [STEP_W-1:0]        step_q;
	logic                     busy_q;
	logic                     done_q;
	logic [CW-1:0]            div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			for (int l = 0; l < SLOTS; l++) begin
				logic [CW:0] trial;
				trial = {rem_q[l], quo_q[l][SUM_W-1]};
				if (trial >= {1'b0, div_q}) begin
					trial = trial - {1'b0, div_q};
					quo_q[l] <= {quo_q[l][SUM_W-2:0], 1'b1};
				end else begin
					quo_q[l] <= {quo_q[l][SUM_W-2:0], 1'b0};
				end
				rem_q[l] <= trial[CW-1:0];
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");

endmodule

// File: src/cnn_dist.sv
// ----------------------------------------------------------------------------
// cnn_dist
// Squared Euclidean distance unit: one feature per cycle through a
// difference stage, a multiply stage and an accumulator.
// ----------------------------------------------------------------------------
module cnn_dist import cnn_pkg::*; #(
	parameter int FEATURE_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  feat_vec_t         a,
	input  feat_vec_t         b,
	output logic [DIST_W-1:0] sum_sq,
	output logic              done
);

	logic [SLOT_W-1:0] f_q;
	logic              run_q;
	logic              v_s1, last_s1, v_s2, last_s2;
	logic [FEAT_W-1:0] diff_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [DIST_W-1:0] acc_q;
	logic              done_q;
	logic [FEAT_W-1:0] xa, xb;
	logic              f_last;

	assign xa     = a[f_q*FEAT_W +: FEAT_W];
	assign xb     = b[f_q*FEAT_W +: FEAT_W];
	assign f_last = (f_q == SLOT_W'(FEATURE_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			f_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= run_q;
			last_s1 <= run_q && f_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			done_q  <= v_s2 && last_s2;
			if (start) begin
				run_q <= 1'b1;
				f_q   <= '0;
			end else if (run_q) begin
				f_q <= f_q + SLOT_W'(1);
				if (f_last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= (xa > xb) ? (xa - xb) : (xb - xa);
		prod_s2 <= diff_s1 * diff_s1;
		if (start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + DIST_W'(prod_s2);
		end
	end

	assign sum_sq = acc_q;
	assign done   = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!run_q && !v_s1 && !v_s2))
		else $error("distance unit restarted while busy");

endmodule

// File: src/cnn_datapath.sv
// ----------------------------------------------------------------------------
// cnn_datapath
// Sample, distance, sorted-order and kept-order memories, feature sums,
// centroid divider, distance unit, nearest search registers and the
// registered result port.
// ----------------------------------------------------------------------------
module cnn_datapath import cnn_pkg::*; #(
	parameter int MAX_SAMPLES   = 64,
	parameter int FEATURE_COUNT = 4,
	parameter int IW            = 6,
	parameter int CW            = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [IW-1:0]      addr,
	input  logic [IW-1:0]      waddr,
	input  logic [CW-1:0]      n,
	output sts_t               sts,
	input  logic [LABEL_W-1:0] class_label,
	input  logic [FEAT_W-1:0]  feature_0,
	input  logic [FEAT_W-1:0]  feature_1,
	input  logic [FEAT_W-1:0]  feature_2,
	input  logic [FEAT_W-1:0]  feature_3,
	output logic               strobe,
	output logic [LABEL_W-1:0] kept_label,
	output logic [FEAT_W-1:0]  kept_feature_0,
	output logic [FEAT_W-1:0]  kept_feature_1,
	output logic [FEAT_W-1:0]  kept_feature_2,
	output logic [FEAT_W-1:0]  kept_feature_3,
	output logic               last_kept
);

	logic [WORD_W-1:0] feat_mem   [MAX_SAMPLES];
	logic [DIST_W-1:0] dist_mem   [MAX_SAMPLES];
	logic [IW-1:0]     sort_mem   [MAX_SAMPLES];
	logic [IW-1:0]     korder_mem [MAX_SAMPLES];

	logic [WORD_W-1:0]  feat_rd_q;
	logic [DIST_W-1:0]  dist_rd_q;
	logic [IW-1:0]      sort_rd_q;
	logic [IW-1:0]      korder_rd_q;
	logic [IW-1:0]      feat_addr;
	logic [IW-1:0]      sel_sample;

	sum_vec_t           sums_q;
	sum_vec_t           quotient;
	logic               div_done;
	feat_vec_t          query_q;
	logic [LABEL_W-1:0] q_label_q;
	logic [DIST_W-1:0]  sum_sq;
	logic               dist_done;
	logic [DIST_W-1:0]  di_q;
	logic [IW-1:0]      rank_q;
	logic [IW-1:0]      s_q;
	logic [DIST_W-1:0]  best_q;
	logic [LABEL_W-1:0] best_label_q;
	logic [MAX_SAMPLES-1:0] flags_q;
	logic               strobe_q;
	logic [WORD_W-1:0]  in_word;

	assign in_word = {class_label, feature_3, feature_2, feature_1, feature_0};

	always_comb begin
		case (cmd.fsel)
			FSEL_ADDR: feat_addr = addr;
			FSEL_SORT: feat_addr = sort_rd_q;
			FSEL_KORD: feat_addr = korder_rd_q;
			default:   feat_addr = addr;
		endcase
	end

	assign sel_sample = cmd.seed ? sort_rd_q : s_q;

	// Memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			feat_mem[waddr] <= in_word;
		end
		if (cmd.feat_rd) begin
			feat_rd_q <= feat_mem[feat_addr];
		end
		if (cmd.dist_wr) begin
			dist_mem[waddr] <= sum_sq;
		end
		if (cmd.dist_rd) begin
			dist_rd_q <= dist_mem[addr];
		end
		if (cmd.sort_wr) begin
			sort_mem[rank_q] <= waddr;
		end
		if (cmd.sort_rd) begin
			sort_rd_q <= sort_mem[addr];
		end
		if (cmd.korder_wr) begin
			korder_mem[waddr] <= sel_sample;
		end
		if (cmd.korder_rd) begin
			korder_rd_q <= korder_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q   <= '0;
			flags_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cmd.clear) begin
				sums_q  <= '0;
				flags_q <= '0;
			end else begin
				if (cmd.load) begin
					for (int f = 0; f < FEATURE_COUNT; f++) begin
						sums_q[f] <= sums_q[f] + SUM_W'(in_word[f*FEAT_W +: FEAT_W]);
					end
				end
				if (cmd.korder_wr) begin
					flags_q[sel_sample] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cen_cap) begin
			for (int f = 0; f < SLOTS; f++) begin
				query_q[f*FEAT_W +: FEAT_W] <= quotient[f][FEAT_W-1:0];
			end
		end else if (cmd.q_cap) begin
			query_q   <= feat_rd_q[VEC_W-1:0];
			q_label_q <= feat_rd_q[WORD_W-1:VEC_W];
		end
		if (cmd.di_cap) begin
			di_q <= dist_rd_q;
		end
		if (cmd.rank_clr) begin
			rank_q <= '0;
		end else if (cmd.rank_step) begin
			if ((dist_rd_q < di_q) || ((dist_rd_q == di_q) && cmd.j_before_i)) begin
				rank_q <= rank_q + IW'(1);
			end
		end
		if (cmd.s_cap) begin
			s_q <= sort_rd_q;
		end
		// First minimum wins: only a strictly smaller distance replaces.
		if (cmd.best_upd && (cmd.best_first || (sum_sq < best_q))) begin
			best_q       <= sum_sq;
			best_label_q <= feat_rd_q[WORD_W-1:VEC_W];
		end
		if (cmd.emit) begin
			kept_label     <= feat_rd_q[WORD_W-1:VEC_W];
			kept_feature_0 <= feat_rd_q[0*FEAT_W +: FEAT_W];
			kept_feature_1 <= feat_rd_q[1*FEAT_W +: FEAT_W];
			kept_feature_2 <= feat_rd_q[2*FEAT_W +: FEAT_W];
			kept_feature_3 <= feat_rd_q[3*FEAT_W +: FEAT_W];
			last_kept      <= cmd.last;
		end
	end

	cnn_div #(
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (n),
		.dividend (sums_q),
		.quotient (quotient),
		.done     (div_done)
	);

	cnn_dist #(
		.FEATURE_COUNT (FEATURE_COUNT)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.dist_start),
		.a      (query_q),
		.b      (feat_rd_q[VEC_W-1:0]),
		.sum_sq (sum_sq),
		.done   (dist_done)
	);

	assign sts.div_done   = div_done;
	assign sts.dist_done  = dist_done;
	assign sts.s_kept     = flags_q[sort_rd_q];
	assign sts.label_diff = (best_label_q != q_label_q);
	assign strobe         = strobe_q;

endmodule

// File: src/cnn_ctrl.sv
// ----------------------------------------------------------------------------
// cnn_ctrl
// Sequencer for load, centroid, ranking sort, condensing passes and
// result readout; holds the sample, kept and loop counters.
// ----------------------------------------------------------------------------
module cnn_ctrl import cnn_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int IW          = 6,
	parameter int CW          = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          end_of_set,
	output logic          busy,
	output cmd_t          cmd,
	output logic [IW-1:0] addr,
	output logic [IW-1:0] waddr,
	output logic [CW-1:0] n,
	input  sts_t          sts
);

	typedef enum logic [4:0] {
		S_IDLE, S_DIVST, S_DIV,
		S_CD_RD, S_CD_ST, S_CD_WT,
		S_SR_RDI, S_SR_CAPI, S_SR_RDJ, S_SR_CMP, S_SR_WR,
		S_CN_SEED_RD, S_CN_SEED_WR, S_CN_RDS, S_CN_CHK, S_CN_LDQ,
		S_CN_RDK, S_CN_RDF, S_CN_DST, S_CN_DWT, S_CN_DEC,
		S_OUT_RDK, S_OUT_RDF, S_OUT_EMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q, kept_q, i_q, j_q;
	logic          added_q;
	logic [CW-1:0] i_nxt, j_nxt;
	logic          not_full;

	assign i_nxt    = i_q + CW'(1);
	assign j_nxt    = j_q + CW'(1);
	assign not_full = (cnt_q < CW'(MAX_SAMPLES));
	assign busy     = (state_q != S_IDLE);
	assign n        = cnt_q;

	always_comb begin
		cmd   = '0;
		addr  = i_q[IW-1:0];
		waddr = i_q[IW-1:0];
		case (state_q)
			S_IDLE: begin
				cmd.load = start && not_full;
				waddr    = cnt_q[IW-1:0];
			end
			S_DIVST:  cmd.div_start = 1'b1;
			S_DIV:    cmd.cen_cap = sts.div_done;
			S_CD_RD: begin
				cmd.feat_rd = 1'b1;
				cmd.fsel    = FSEL_ADDR;
			end
			S_CD_ST:  cmd.dist_start = 1'b1;
			S_CD_WT:  cmd.dist_wr = sts.dist_done;
			S_SR_RDI: cmd.dist_rd = 1'b1;
			S_SR_CAPI: begin
				cmd.di_cap   = 1'b1;
				cmd.rank_clr = 1'b1;
			end
			S_SR_RDJ: begin
				cmd.dist_rd = 1'b1;
				addr        = j_q[IW-1:0];
			end
			S_SR_CMP: begin
				cmd.rank_step  = 1'b1;
				cmd.j_before_i = (j_q < i_q);
			end
			S_SR_WR:  cmd.sort_wr = 1'b1;
			S_CN_SEED_RD: begin
				cmd.sort_rd = 1'b1;
				addr        = '0;
			end
			S_CN_SEED_WR: begin
				cmd.korder_wr = 1'b1;
				cmd.seed      = 1'b1;
				waddr         = '0;
			end
			S_CN_RDS: cmd.sort_rd = (i_q != cnt_q);
			S_CN_CHK: begin
				cmd.s_cap   = 1'b1;
				cmd.feat_rd = !sts.s_kept;
				cmd.fsel    = FSEL_SORT;
			end
			S_CN_LDQ: cmd.q_cap = 1'b1;
			S_CN_RDK, S_OUT_RDK: begin
				cmd.korder_rd = 1'b1;
				addr          = j_q[IW-1:0];
			end
			S_CN_RDF, S_OUT_RDF: begin
				cmd.feat_rd = 1'b1;
				cmd.fsel    = FSEL_KORD;
			end
			S_CN_DST: cmd.dist_start = 1'b1;
			S_CN_DWT: begin
				cmd.best_upd   = sts.dist_done;
				cmd.best_first = (j_q == '0);
			end
			S_CN_DEC: begin
				cmd.korder_wr = sts.label_diff && (kept_q < CW'(MAX_SAMPLES));
				waddr         = kept_q[IW-1:0];
			end
			S_OUT_EMIT: begin
				cmd.emit  = 1'b1;
				cmd.last  = (j_nxt == kept_q);
				cmd.clear = (j_nxt == kept_q);
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			kept_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			added_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (not_full) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (end_of_set) begin
							state_q <= S_DIVST;
						end
					end
				end
				S_DIVST: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) begin
						i_q     <= '0;
						state_q <= S_CD_RD;
					end
				end
				S_CD_RD: state_q <= S_CD_ST;
				S_CD_ST: state_q <= S_CD_WT;
				S_CD_WT: begin
					if (sts.dist_done) begin
						if (i_nxt == cnt_q) begin
							i_q     <= '0;
							state_q <= S_SR_RDI;
						end else begin
							i_q     <= i_nxt;
							state_q <= S_CD_RD;
						end
					end
				end
				S_SR_RDI: state_q <= S_SR_CAPI;
				S_SR_CAPI: begin
					j_q     <= '0;
					state_q <= S_SR_RDJ;
				end
				S_SR_RDJ: state_q <= S_SR_CMP;
				S_SR_CMP: begin
					j_q     <= j_nxt;
					state_q <= (j_nxt == cnt_q) ? S_SR_WR : S_SR_RDJ;
				end
				S_SR_WR: begin
					if (i_nxt == cnt_q) begin
						state_q <= S_CN_SEED_RD;
					end else begin
						i_q     <= i_nxt;
						state_q <= S_SR_RDI;
					end
				end
				S_CN_SEED_RD: state_q <= S_CN_SEED_WR;
				S_CN_SEED_WR: begin
					kept_q  <= CW'(1);
					added_q <= 1'b0;
					i_q     <= CW'(1);
					state_q <= S_CN_RDS;
				end
				S_CN_RDS: begin
					if (i_q == cnt_q) begin
						if (added_q) begin
							added_q <= 1'b0;
							i_q     <= CW'(1);
						end else begin
							j_q     <= '0;
							state_q <= S_OUT_RDK;
						end
					end else begin
						state_q <= S_CN_CHK;
					end
				end
				S_CN_CHK: begin
					if (sts.s_kept) begin
						i_q     <= i_nxt;
						state_q <= S_CN_RDS;
					end else begin
						j_q     <= '0;
						state_q <= S_CN_LDQ;
					end
				end
				S_CN_LDQ: state_q <= S_CN_RDK;
				S_CN_RDK: state_q <= S_CN_RDF;
				S_CN_RDF: state_q <= S_CN_DST;
				S_CN_DST: state_q <= S_CN_DWT;
				S_CN_DWT: begin
					if (sts.dist_done) begin
						j_q     <= j_nxt;
						state_q <= (j_nxt == kept_q) ? S_CN_DEC : S_CN_RDK;
					end
				end
				S_CN_DEC: begin
					if (sts.label_diff && (kept_q < CW'(MAX_SAMPLES))) begin
						kept_q  <= kept_q + CW'(1);
						added_q <= 1'b1;
					end
					i_q     <= i_nxt;
					state_q <= S_CN_RDS;
				end
				S_OUT_RDK: state_q <= S_OUT_RDF;
				S_OUT_RDF: state_q <= S_OUT_EMIT;
				S_OUT_EMIT: begin
					if (j_nxt == kept_q) begin
						cnt_q   <= '0;
						kept_q  <= '0;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						j_q     <= j_nxt;
						state_q <= S_OUT_RDK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_kept_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= cnt_q) else $error("kept count exceeds sample count");

	a_cnt_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SAMPLES)) else $error("sample count beyond capacity");

	a_i_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= cnt_q) else $error("sample index beyond sample count");

endmodule
